// ===== rtl/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key table package
// Shared constants, payload structs and controller/datapath interface types.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int KEY_BITS   = 31;
    localparam int FIELD_BITS = 7;
    localparam int CAP_RESET  = 64;

    // Operation codes. Any other code is answered as a search.
    localparam logic [1:0] OP_SEARCH = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]          operation;
        logic [KEY_BITS-1:0] key;
    } skt_in_t;

    typedef struct packed {
        logic                  success;
        logic                  found;
        logic [FIELD_BITS-1:0] position;
        logic [FIELD_BITS-1:0] count;
    } skt_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // capture a new transaction, open the search window
        logic probe;        // read the middle entry of the search window
        logic update;       // narrow the window from the probed entry
        logic decide;       // search done: settle success and the shift start
        logic shift_read;   // read the next entry to be moved
        logic shift_write;  // write the moved entry and step the index
        logic commit;       // place the new key and raise the count, or drop the count
        logic finish;       // load the result register
    } skt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic lo_lt_hi;     // search window not yet empty
        logic ins_ok;       // an insert may proceed
        logic rem_ok;       // a remove may proceed
        logic shift_more;   // entries remain to be moved
    } skt_stat_t;

endpackage

// ===== rtl/skt_datapath.sv =====
// ----------------------------------------------------------------------------
// Sorted key table datapath
// Key memory, binary search window, shift index, entry count and result.
// ----------------------------------------------------------------------------
module skt_datapath #(
    parameter int DEPTH = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  skt_pkg::skt_in_t                 in_data,
    input  logic [skt_pkg::FIELD_BITS-1:0]   capacity,
    input  skt_pkg::skt_cmd_t                cmd,
    output skt_pkg::skt_stat_t               stat,
    output skt_pkg::skt_out_t                out_data
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > skt_pkg::FIELD_BITS) ? CW : skt_pkg::FIELD_BITS;

    logic [skt_pkg::KEY_BITS-1:0] mem [DEPTH];

    logic [skt_pkg::KEY_BITS-1:0] key_reg, key_next;
    logic [1:0]                   op_reg, op_next;
    logic [CW-1:0]                lo_reg, lo_next;
    logic [CW-1:0]                hi_reg, hi_next;
    logic [CW-1:0]                mid_reg, mid_next;
    logic [CW-1:0]                idx_reg, idx_next;
    logic [CW-1:0]                count_reg, count_next;
    logic                         found_reg, found_next;
    logic                         success_reg, success_next;
    logic [skt_pkg::KEY_BITS-1:0] rd_data_reg;
    skt_pkg::skt_out_t            out_reg, out_next;

    logic          is_insert, is_remove, full;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic [CW-1:0] src;
    logic [CMPW-1:0] cap_ext, depth_ext, eff_cap;
    logic          mem_re, mem_we;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [skt_pkg::KEY_BITS-1:0] wr_data;

    assign is_insert = (op_reg == skt_pkg::OP_INSERT);
    assign is_remove = (op_reg == skt_pkg::OP_REMOVE);

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CW:1];

    // An insert moves entries up (source below the target), a remove down.
    assign src = is_insert ? (idx_reg - CW'(1)) : (idx_reg + CW'(1));

    assign cap_ext   = CMPW'(capacity);
    assign depth_ext = CMPW'(DEPTH);
    assign eff_cap   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
    assign full      = (CMPW'(count_reg) >= eff_cap);

    assign stat.lo_lt_hi   = (lo_reg < hi_reg);
    assign stat.ins_ok     = is_insert && !full && !found_reg;
    assign stat.rem_ok     = is_remove && found_reg;
    assign stat.shift_more = is_insert ? (idx_reg > lo_reg)
                                       : (({1'b0, idx_reg} + (CW+1)'(1)) < {1'b0, count_reg});

    always_comb begin
        key_next     = key_reg;
        op_next      = op_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        found_next   = found_reg;
        success_next = success_reg;
        out_next     = out_reg;
        if (cmd.load) begin
            key_next   = in_data.key;
            op_next    = in_data.operation;
            lo_next    = '0;
            hi_next    = count_reg;
            found_next = 1'b0;
        end
        if (cmd.probe) begin
            mid_next = mid;
        end
        if (cmd.update) begin
            if (rd_data_reg < key_reg) begin
                lo_next = mid_reg + CW'(1);
            end else begin
                hi_next = mid_reg;
            end
            if (rd_data_reg == key_reg) begin
                found_next = 1'b1;
            end
        end
        if (cmd.decide) begin
            if (is_insert) begin
                success_next = stat.ins_ok;
                idx_next     = count_reg;
            end else if (is_remove) begin
                success_next = stat.rem_ok;
                idx_next     = lo_reg;
            end else begin
                success_next = found_reg;
                idx_next     = lo_reg;
            end
        end
        if (cmd.shift_write) begin
            idx_next = src;
        end
        if (cmd.commit) begin
            count_next = is_insert ? (count_reg + CW'(1)) : (count_reg - CW'(1));
        end
        if (cmd.finish) begin
            out_next.success  = success_reg;
            out_next.found    = found_reg;
            out_next.position = skt_pkg::FIELD_BITS'(lo_reg);
            out_next.count    = skt_pkg::FIELD_BITS'(count_reg);
        end
    end

    // Memory port selection: reads serve the search probe or the shift source.
    assign mem_re  = cmd.probe || cmd.shift_read;
    assign rd_addr = cmd.probe ? mid[AW-1:0] : src[AW-1:0];
    assign mem_we  = cmd.shift_write || (cmd.commit && is_insert);
    assign wr_addr = cmd.shift_write ? idx_reg[AW-1:0] : lo_reg[AW-1:0];
    assign wr_data = cmd.shift_write ? rd_data_reg : key_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        op_reg      <= op_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        idx_reg     <= idx_next;
        found_reg   <= found_next;
        success_reg <= success_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign out_data = out_reg;

endmodule

// ===== rtl/skt_controller.sv =====
// ----------------------------------------------------------------------------
// Sorted key table controller
// Sequences search, shift and commit steps and owns both handshakes.
// ----------------------------------------------------------------------------
module skt_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  skt_pkg::skt_stat_t stat,
    output skt_pkg::skt_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SEARCH = 6'b000010,
        ST_CMP    = 6'b000100,
        ST_SH_CHK = 6'b001000,
        ST_SH_WR  = 6'b010000,
        ST_FIN    = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (stat.lo_lt_hi) begin
                    cmd.probe  = 1'b1;
                    state_next = ST_CMP;
                end else begin
                    cmd.decide = 1'b1;
                    state_next = (stat.ins_ok || stat.rem_ok) ? ST_SH_CHK : ST_FIN;
                end
            end
            ST_CMP: begin
                cmd.update = 1'b1;
                state_next = ST_SEARCH;
            end
            ST_SH_CHK: begin
                if (stat.shift_more) begin
                    cmd.shift_read = 1'b1;
                    state_next     = ST_SH_WR;
                end else begin
                    cmd.commit = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_SH_WR: begin
                cmd.shift_write = 1'b1;
                state_next      = ST_SH_CHK;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/sorted_key_table.sv =====
// ----------------------------------------------------------------------------
// Sorted key table
// Ordered table of distinct keys with search, insert and remove transactions.
// ----------------------------------------------------------------------------
// A search takes one probe read and one compare per binary search step, for
// at most ceil(log2(count + 1)) probes; an insert or remove that succeeds
// then moves the entries one at a time before it commits. One transaction
// is worked on at a time; the next one can be accepted in the cycle after
// the result is loaded.
// Reset (synchronous, active low) empties the table and sets capacity to 64.
// ----------------------------------------------------------------------------
module sorted_key_table #(
    parameter int DEPTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  skt_pkg::skt_in_t               s_data,
    // Result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output skt_pkg::skt_out_t              m_data,
    // Capacity register write port
    input  logic                           cfg_wr_en,
    input  logic [skt_pkg::FIELD_BITS-1:0] cfg_wr_data
);

    // The capacity register limits inserts only. A value above DEPTH behaves
    // as DEPTH, and a value below the current count blocks further inserts
    // while leaving the held keys and removes untouched.
    logic [skt_pkg::FIELD_BITS-1:0] capacity_reg;

    skt_pkg::skt_cmd_t  cmd;
    skt_pkg::skt_stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= skt_pkg::FIELD_BITS'(skt_pkg::CAP_RESET);
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // The controller walks each transaction through a binary search over the
    // key memory (one probe read and one compare per step), then, for an
    // insert or remove that succeeds, a shift of the entries above the
    // lower-bound position one at a time, and finally the count update. The
    // result goes into an output register so the next transaction can be
    // accepted while the previous result waits for the consumer.
    skt_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds the key memory, the search window, the shift index,
    // the entry count and the result register. Only entries below the count
    // are ever read, so the memory needs no clearing after reset.
    skt_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_data),
        .capacity (capacity_reg),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_data)
    );

    // A new transaction is never taken while one is still being worked on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a transaction is in progress");

    // The controller issues at most one datapath step per cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.probe, cmd.update, cmd.decide,
                  cmd.shift_read, cmd.shift_write, cmd.commit, cmd.finish}))
        else $error("more than one datapath command in a cycle");

    // A probe is only issued while the search window is still open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.probe |-> stat.lo_lt_hi)
        else $error("probe issued on an empty search window");

    // A result is only loaded when the output register is free or draining.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_valid || m_ready))
        else $error("result register overwritten before it was taken");

endmodule
